// File: rtl/core/bsws_pkg.sv
package bsws_pkg;

    localparam int VALUE_W = 32;

    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_POP    = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]                command;
        logic signed [VALUE_W-1:0] value;
    } t_item;

    typedef struct packed {
        logic [1:0]                status;
        logic signed [VALUE_W-1:0] popped_value;
        logic                      found;
        logic [3:0]                found_position;
        logic [3:0]                entry_count;
        logic                      is_full;
        logic                      is_empty;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_SCAN = 3'b100
    } t_state;

endpackage

// File: rtl/core/bsws_mem.sv
module bsws_mem import bsws_pkg::*; #(
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [AW-1:0]             i_wr_addr,
    input  logic signed [VALUE_W-1:0] i_wr_data,
    input  logic [AW-1:0]             i_rd_addr,
    output logic signed [VALUE_W-1:0] o_rd_data
);

    logic signed [VALUE_W-1:0] r_mem [DEPTH];
    logic signed [VALUE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/bsws_ctrl.sv
module bsws_ctrl import bsws_pkg::*; #(
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  t_item                     i_item,
    output logic                      o_busy,
    output logic                      o_done,
    output t_result                   o_result,
    output logic                      o_wr_en,
    output logic [AW-1:0]             o_wr_addr,
    output logic signed [VALUE_W-1:0] o_wr_data,
    output logic [AW-1:0]             o_rd_addr,
    input  logic signed [VALUE_W-1:0] i_rd_data
);

    localparam int EW = (CW > 4) ? CW : 4;
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_state                    r_state, n_state;
    logic [CW-1:0]             r_count, n_count;
    logic [AW-1:0]             r_idx, n_idx;
    logic signed [VALUE_W-1:0] r_value, n_value;
    logic [CW-1:0]             scan_pos;
    logic [EW-1:0]             pos_wide;
    logic [EW-1:0]             cnt_wide;

    // Position of the entry now on the read port, counted from one.
    assign scan_pos = CW'(r_idx) + CW'(1);
    assign pos_wide = EW'(scan_pos);
    assign cnt_wide = EW'(n_count);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_value   = r_value;
        o_wr_en   = 1'b0;
        o_wr_addr = r_count[AW-1:0];
        o_wr_data = i_item.value;
        o_rd_addr = r_idx;
        o_done    = 1'b0;
        o_result  = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_item.command)
                        CMD_PUSH: begin
                            o_done = 1'b1;
                            if (r_count == FULL_CNT) begin
                                o_result.status = ST_FULL;
                            end else begin
                                o_wr_en = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        CMD_POP: begin
                            if (r_count == '0) begin
                                o_done          = 1'b1;
                                o_result.status = ST_EMPTY;
                            end else begin
                                n_count   = r_count - CW'(1);
                                o_rd_addr = n_count[AW-1:0];
                                n_state   = S_READ;
                            end
                        end
                        CMD_SEARCH: begin
                            if (r_count == '0) begin
                                o_done          = 1'b1;
                                o_result.status = ST_EMPTY;
                            end else begin
                                n_idx     = '0;
                                o_rd_addr = '0;
                                n_value   = i_item.value;
                                n_state   = S_SCAN;
                            end
                        end
                        default: begin
                            o_done = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                o_done                = 1'b1;
                o_result.popped_value = i_rd_data;
                n_state               = S_IDLE;
            end
            S_SCAN: begin
                if (i_rd_data == r_value) begin
                    o_done                  = 1'b1;
                    o_result.found          = 1'b1;
                    o_result.found_position = pos_wide[3:0];
                    n_state                 = S_IDLE;
                end else if (scan_pos == r_count) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_idx     = r_idx + AW'(1);
                    o_rd_addr = n_idx;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        o_result.entry_count = cnt_wide[3:0];
        o_result.is_full     = (n_count == FULL_CNT);
        o_result.is_empty    = (n_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_value <= n_value;
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// File: rtl/core/bounded_stack_with_search_unit.sv
// Bounded LIFO stack of DEPTH signed 32-bit words with a linear search.
// Command channel: a transfer happens at a clock edge with start high and
// busy low; i_item carries the command (push, pop, search) and the value.
// Result channel: o_valid is high for exactly one cycle with o_result; the
// receiver cannot hold it off, so nothing ever waits on the output side.
// The words live in a single-port-write, registered-read memory; the count
// of held entries is a register next to it.
// Push, refused commands and the unused command are answered from idle,
// with only the o_valid/o_result register after the controller; a pop
// passes the read state, where the registered memory read returns the word;
// a search reads one entry per cycle through the memory read port from the
// bottom until a match or the top entry. A new command can be accepted in
// the cycle o_valid is high; busy refuses commands while a pop or search runs.
// Reset clears the count and returns the sequencer to idle; the memory
// is not cleared, since only entries below the count are ever read.
module bounded_stack_with_search_unit import bsws_pkg::*; #(
    parameter int DEPTH = 8
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_item   i_item,
    output logic    o_valid,
    output t_result o_result
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic signed [VALUE_W-1:0] wr_data;
    logic [AW-1:0]             rd_addr;
    logic signed [VALUE_W-1:0] rd_data;
    logic                      done;
    t_result                   result;
    logic                      r_valid;
    t_result                   r_result;

    bsws_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    bsws_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_item    (i_item),
        .o_busy    (busy),
        .o_done    (done),
        .o_result  (result),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_result <= result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    // A push always completes in the cycle it is accepted.
    a_push_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_item.command == CMD_PUSH) |=> o_valid)
        else $error("push result did not follow its transfer");

    // The sequencer is idle again whenever a result is presented.
    a_idle_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result presented while a command is still running");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result.status == ST_FULL) |-> o_result.is_full)
        else $error("refused push without full flag");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.found |-> (o_result.status == ST_OK) && !o_result.is_empty)
        else $error("match reported on an empty stack or with error status");

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps

module tb;
    import bsws_pkg::*;

    localparam int STACK_DEPTH = 8;
    localparam int RANDOM_ITEMS = 1930;
    localparam int BLOCK_LEN = 150;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        t_item   item;
        bit      typed;
        t_result want;
    } t_step;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_item   i_item;
    logic    o_valid;
    t_result o_result;

    // Shadow copy of the stack contents and the queue of results still owed.
    logic signed [31:0] stack_words [STACK_DEPTH];
    int                 held_count;
    t_result            pending_results [$];
    t_step              directed_rows [$];

    int error_count;
    int n_push_ok, n_push_full, n_pop_ok, n_empty_refused;
    int n_search_hit, n_search_miss, n_unused, n_full_seen;

    bounded_stack_with_search_unit #(
        .DEPTH(STACK_DEPTH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("** bounded_stack_with_search_unit: FAILED **");
        $finish;
    end

    function automatic t_result apply_stack_command(input t_item it);
        t_result r;
        r = '0;
        r.status = ST_OK;
        case (it.command)
            CMD_PUSH: begin
                if (held_count >= STACK_DEPTH) begin
                    r.status = ST_FULL;
                    n_push_full++;
                end else begin
                    stack_words[held_count] = it.value;
                    held_count++;
                    n_push_ok++;
                    if (held_count == STACK_DEPTH) n_full_seen++;
                end
            end
            CMD_POP: begin
                if (held_count == 0) begin
                    r.status = ST_EMPTY;
                    n_empty_refused++;
                end else begin
                    held_count--;
                    r.popped_value = stack_words[held_count];
                    stack_words[held_count] = '0;
                    n_pop_ok++;
                end
            end
            CMD_SEARCH: begin
                if (held_count == 0) begin
                    r.status = ST_EMPTY;
                    n_empty_refused++;
                end else begin
                    // The first match counted from the bottom wins.
                    for (int k = 0; k < held_count; k++) begin
                        if (!r.found && stack_words[k] == it.value) begin
                            r.found = 1'b1;
                            r.found_position = 4'(k + 1);
                        end
                    end
                    if (r.found) n_search_hit++;
                    else n_search_miss++;
                end
            end
            default: begin
                n_unused++;
            end
        endcase
        r.entry_count = 4'(held_count);
        r.is_full = (held_count == STACK_DEPTH);
        r.is_empty = (held_count == 0);
        return r;
    endfunction

    function automatic logic signed [31:0] random_word();
        case ($urandom_range(0, 9))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return '0;
            3: return -32'sd1;
            4: return 32'($urandom_range(0, 7));
            default: return $urandom;
        endcase
    endfunction

    function automatic t_item random_command(input int push_pct);
        t_item it;
        int    r;
        r = $urandom_range(0, 99);
        it.value = $urandom;
        if (r < push_pct) begin
            it.command = CMD_PUSH;
            it.value = random_word();
        end else if (r < push_pct + (95 - push_pct) * 55 / 100) begin
            it.command = CMD_POP;
        end else if (r < 95) begin
            it.command = CMD_SEARCH;
            // Most searches look for a word that is held, so hits are common.
            if (held_count > 0 && $urandom_range(0, 2) != 0)
                it.value = stack_words[$urandom_range(0, held_count - 1)];
            else
                it.value = random_word();
        end else begin
            it.command = CMD_UNUSED;
        end
        return it;
    endfunction

    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    function automatic void add_row(input logic [1:0] cmd, input logic signed [31:0] val,
                                    input bit typed, input t_result want);
        t_step s;
        s.item.command = cmd;
        s.item.value = val;
        s.typed = typed;
        s.want = want;
        directed_rows.push_back(s);
    endfunction

    // One transfer on the command side; the expectation is queued at the
    // accepting edge, in command order.
    task automatic send_command(input t_item it, input bit typed, input t_result want,
                                input int gap);
        t_result predicted;
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        predicted = apply_stack_command(it);
        pending_results.push_back(typed ? want : predicted);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic check_result(input t_result got, input t_result want);
        if (got.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, got.status);
            error_count++;
        end
        if (got.popped_value !== want.popped_value) begin
            $error("popped_value mismatch: expected %0d, got %0d",
                   want.popped_value, got.popped_value);
            error_count++;
        end
        if (got.found !== want.found) begin
            $error("found mismatch: expected %0d, got %0d", want.found, got.found);
            error_count++;
        end
        if (got.found_position !== want.found_position) begin
            $error("found_position mismatch: expected %0d, got %0d",
                   want.found_position, got.found_position);
            error_count++;
        end
        if (got.entry_count !== want.entry_count) begin
            $error("entry_count mismatch: expected %0d, got %0d",
                   want.entry_count, got.entry_count);
            error_count++;
        end
        if (got.is_full !== want.is_full) begin
            $error("is_full mismatch: expected %0d, got %0d", want.is_full, got.is_full);
            error_count++;
        end
        if (got.is_empty !== want.is_empty) begin
            $error("is_empty mismatch: expected %0d, got %0d", want.is_empty, got.is_empty);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no command outstanding");
                error_count++;
            end else begin
                check_result(o_result, pending_results.pop_front());
            end
        end
    end

    initial begin
        t_item   it;
        int      push_pct;
        bit      calm;

        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        held_count = 0;
        error_count = 0;
        foreach (stack_words[k]) stack_words[k] = '0;

        // Refusals and the unused command on an empty stack, then fill it
        // with extremes and a duplicate, overflow it, and search both ends.
        add_row(CMD_POP, $urandom, 1,
                t_result'{ST_EMPTY, 32'sd0, 1'b0, 4'd0, 4'd0, 1'b0, 1'b1});
        add_row(CMD_SEARCH, 32'sd0, 1,
                t_result'{ST_EMPTY, 32'sd0, 1'b0, 4'd0, 4'd0, 1'b0, 1'b1});
        add_row(CMD_UNUSED, $urandom, 1,
                t_result'{ST_OK, 32'sd0, 1'b0, 4'd0, 4'd0, 1'b0, 1'b1});
        add_row(CMD_PUSH, WORD_MIN, 1,
                t_result'{ST_OK, 32'sd0, 1'b0, 4'd0, 4'd1, 1'b0, 1'b0});
        add_row(CMD_PUSH, WORD_MAX, 0, '0);
        add_row(CMD_PUSH, 32'sd0, 0, '0);
        add_row(CMD_PUSH, -32'sd1, 0, '0);
        add_row(CMD_PUSH, 32'sd0, 0, '0);
        add_row(CMD_PUSH, 32'sh5555_5555, 0, '0);
        add_row(CMD_PUSH, 32'shAAAA_AAAA, 0, '0);
        add_row(CMD_PUSH, 32'sh1234_5678, 0, '0);
        add_row(CMD_PUSH, 32'sd99, 1,
                t_result'{ST_FULL, 32'sd0, 1'b0, 4'd0, 4'd8, 1'b1, 1'b0});
        add_row(CMD_UNUSED, $urandom, 1,
                t_result'{ST_OK, 32'sd0, 1'b0, 4'd0, 4'd8, 1'b1, 1'b0});
        add_row(CMD_SEARCH, WORD_MIN, 0, '0);
        add_row(CMD_SEARCH, WORD_MAX, 0, '0);
        add_row(CMD_SEARCH, 32'sd0, 0, '0);
        add_row(CMD_SEARCH, 32'sh1234_5678, 0, '0);
        add_row(CMD_SEARCH, 32'sh0BAD_F00D, 0, '0);
        add_row(CMD_POP, $urandom, 0, '0);
        add_row(CMD_POP, $urandom, 0, '0);
        add_row(CMD_SEARCH, 32'shAAAA_AAAA, 0, '0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k])
            send_command(directed_rows[k].item, directed_rows[k].typed,
                         directed_rows[k].want, pick_gap(1'b0));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % BLOCK_LEN == 0) begin
                case ($urandom_range(0, 2))
                    0: push_pct = 30;
                    1: push_pct = 45;
                    default: push_pct = 65;
                endcase
                calm = ($urandom_range(0, 3) == 0);
            end
            // Now and then let the block drain completely before going on.
            if (n % 400 == 399 && pending_results.size() != 0) begin
                start <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
            end
            it = random_command(push_pct);
            send_command(it, 1'b0, '0, pick_gap(calm));
        end

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (STACK_DEPTH + 4) @(posedge i_clk);

        $display("Commands: %0d pushes stored, %0d refused as full, %0d pops, %0d unused.",
                 n_push_ok, n_push_full, n_pop_ok, n_unused);
        $display("Searches: %0d hits, %0d misses; %0d empty refusals; stack filled %0d times.",
                 n_search_hit, n_search_miss, n_empty_refused, n_full_seen);
        if (error_count == 0) begin
            $display("** bounded_stack_with_search_unit: PASSED **");
        end else begin
            $display("** bounded_stack_with_search_unit: FAILED **");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/bsws_pkg.sv
rtl/core/bsws_mem.sv
rtl/core/bsws_ctrl.sv
rtl/core/bounded_stack_with_search_unit.sv
sim/tb.sv
